// ===== design/bldc6_pkg.sv =====
// Shared constants for the six-step BLDC test sequencer: command codes,
// event codes, register indexes, reset values and divide-by-1000 constants.
// No dependencies.
package bldc6_pkg;

	// Command codes carried by op
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_ARM   = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	// Event codes reported per transfer
	localparam logic [3:0] EV_NONE           = 4'd0;
	localparam logic [3:0] EV_ARMED          = 4'd1;
	localparam logic [3:0] EV_ARM_FAULT      = 4'd2;
	localparam logic [3:0] EV_STARTED        = 4'd3;
	localparam logic [3:0] EV_REJECT_UNARMED = 4'd4;
	localparam logic [3:0] EV_FAULT_PRETEST  = 4'd5;
	localparam logic [3:0] EV_COMPLETE       = 4'd6;
	localparam logic [3:0] EV_ABORT_FAULT    = 4'd7;
	localparam logic [3:0] EV_ABORT_USER     = 4'd8;
	localparam logic [3:0] EV_USER_STOP      = 4'd9;
	localparam logic [3:0] EV_FAULT          = 4'd10;
	localparam logic [3:0] EV_ARM_TIMEOUT    = 4'd11;

	// Configuration register indexes
	localparam logic [2:0] REG_PWM_TOP     = 3'd0;
	localparam logic [2:0] REG_DUTY        = 3'd1;
	localparam logic [2:0] REG_ARM_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_STEP_PERIOD = 3'd3;
	localparam logic [2:0] REG_STEP_COUNT  = 3'd4;

	// Configuration reset values
	localparam logic [15:0] RST_PWM_TOP     = 16'd6249;
	localparam logic [9:0]  RST_DUTY        = 10'd120;
	localparam logic [15:0] RST_ARM_TIMEOUT = 16'd10000;
	localparam logic [15:0] RST_STEP_PERIOD = 16'd100;
	localparam logic [7:0]  RST_STEP_COUNT  = 8'd24;

	// Duty ceiling in thousandths
	localparam logic [9:0] DUTY_MAX = 10'd1000;

	// Divide by 1000: q = (p * RECIP_1000) >> RECIP_SHIFT, exact for p < 2**26
	localparam int unsigned RECIP_SHIFT = 36;
	localparam logic [26:0] RECIP_1000  = 27'd68719477;

	// Commutation position (0..5)
	typedef logic [2:0] position_t;
	localparam position_t POS_LAST = 3'd5;

endpackage

// ===== design/bldc_six_step_test_sequencer_core.sv =====
// Six-step BLDC test sequencer: mode logic, step timing and compare levels.
// Depends on bldc6_pkg.
//
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_ready    op, fault_pin
// out      source     out_valid/out_ready  driver_enable, mode, event_code,
//                                          step_number, u/v/w high/low levels
// cfg      sink       cfg_we (no wait)     cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an input transfer loads
// stage 1, and stage 1 then moves to the output register behind out_valid.
// Stage 1 updates the mode state and forms (pwm_top+1)*duty; stage 2 divides
// by 1000 with a reciprocal multiply and routes the levels to the phases.
// A stalled output holds stage 2; stage 1 keeps accepting while stage 2 is
// free, so up to two results can be in flight.
// arst_n clears the mode state and both stage valids, and resets the config.
module bldc_six_step_test_sequencer_core
	import bldc6_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        fault_pin,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic        driver_enable,
	output logic [1:0]  mode,
	output logic [3:0]  event_code,
	output logic [7:0]  step_number,
	output logic [16:0] u_high_level,
	output logic [16:0] u_low_level,
	output logic [16:0] v_high_level,
	output logic [16:0] v_low_level,
	output logic [16:0] w_high_level,
	output logic [16:0] w_low_level
);

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ARMED = 2'd1,
		MODE_RUN   = 2'd2
	} mode_t;

	// configuration registers
	logic [15:0] pwm_top_q;
	logic [9:0]  duty_q;
	logic [15:0] arm_timeout_q;
	logic [15:0] step_period_q;
	logic [7:0]  step_count_q;

	// sequencer state
	mode_t       run_mode_q;
	logic [15:0] arm_rem_q;
	logic [15:0] step_rem_q;
	logic [7:0]  step_cnt_q;
	position_t   pos_q;

	// next state
	mode_t       run_mode_d;
	logic [15:0] arm_rem_d;
	logic [15:0] step_rem_d;
	logic [7:0]  step_cnt_d;
	position_t   pos_d;
	logic [3:0]  event_d;

	// stage 1
	logic        valid_s1;
	mode_t       mode_s1;
	logic [3:0]  event_s1;
	logic [7:0]  step_s1;
	position_t   pos_s1;
	logic [16:0] full_s1;
	logic [25:0] prod_s1;

	// stage 2
	logic        valid_s2;
	logic [1:0]  mode_s2;
	logic [3:0]  event_s2;
	logic [7:0]  step_s2;
	logic [16:0] lvl_s2 [6];

	logic        accept;
	logic        advance;
	logic [15:0] arm_load;
	logic [15:0] step_load;
	logic [7:0]  step_cnt_inc;
	logic [16:0] full;
	logic [9:0]  duty_sat;
	logic [26:0] prod_full;
	logic [52:0] quot_full;
	logic [16:0] src_level;
	logic [16:0] lvl_d [6];

	// handshake: stage 2 frees when empty or taken, stage 1 when it can move on
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;
	assign accept   = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q     <= RST_PWM_TOP;
			duty_q        <= RST_DUTY;
			arm_timeout_q <= RST_ARM_TIMEOUT;
			step_period_q <= RST_STEP_PERIOD;
			step_count_q  <= RST_STEP_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_TOP:     pwm_top_q     <= cfg_data;
				REG_DUTY:        duty_q        <= cfg_data[9:0];
				REG_ARM_TIMEOUT: arm_timeout_q <= cfg_data;
				REG_STEP_PERIOD: step_period_q <= cfg_data;
				REG_STEP_COUNT:  step_count_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// zero reload values count as one tick
	assign arm_load     = (arm_timeout_q == 16'd0) ? 16'd1 : arm_timeout_q;
	assign step_load    = (step_period_q == 16'd0) ? 16'd1 : step_period_q;
	assign step_cnt_inc = step_cnt_q + 8'd1;

	// mode and timer update for one item
	always_comb begin
		run_mode_d = run_mode_q;
		arm_rem_d  = arm_rem_q;
		step_rem_d = step_rem_q;
		step_cnt_d = step_cnt_q;
		pos_d      = pos_q;
		event_d    = EV_NONE;
		if (run_mode_q == MODE_RUN) begin
			if (fault_pin) begin
				run_mode_d = MODE_OFF;
				event_d    = EV_ABORT_FAULT;
			end else if (op == OP_STOP) begin
				run_mode_d = MODE_OFF;
				event_d    = EV_ABORT_USER;
			end else if (op == OP_TICK) begin
				if (step_rem_q > 16'd1) begin
					step_rem_d = step_rem_q - 16'd1;
				end else if (step_cnt_inc >= step_count_q) begin
					run_mode_d = MODE_OFF;
					event_d    = EV_COMPLETE;
				end else begin
					step_cnt_d = step_cnt_inc;
					pos_d      = (pos_q >= POS_LAST) ? '0 : pos_q + 3'd1;
					step_rem_d = step_load;
				end
			end
		end else begin
			case (op)
				OP_TICK: begin
					if (run_mode_q == MODE_ARMED) begin
						if (fault_pin) begin
							run_mode_d = MODE_OFF;
							event_d    = EV_FAULT;
						end else if (arm_rem_q <= 16'd1) begin
							run_mode_d = MODE_OFF;
							event_d    = EV_ARM_TIMEOUT;
						end else begin
							arm_rem_d = arm_rem_q - 16'd1;
						end
					end
				end
				OP_ARM: begin
					if (fault_pin) begin
						run_mode_d = MODE_OFF;
						event_d    = EV_ARM_FAULT;
					end else begin
						run_mode_d = MODE_ARMED;
						step_rem_d = '0;
						step_cnt_d = '0;
						pos_d      = '0;
						arm_rem_d  = arm_load;
						event_d    = EV_ARMED;
					end
				end
				OP_START: begin
					if (run_mode_q != MODE_ARMED) begin
						event_d = EV_REJECT_UNARMED;
					end else if (fault_pin) begin
						run_mode_d = MODE_OFF;
						event_d    = EV_FAULT_PRETEST;
					end else if (step_count_q == 8'd0) begin
						run_mode_d = MODE_OFF;
						event_d    = EV_COMPLETE;
					end else begin
						run_mode_d = MODE_RUN;
						arm_rem_d  = '0;
						step_cnt_d = '0;
						pos_d      = '0;
						step_rem_d = step_load;
						event_d    = EV_STARTED;
					end
				end
				default: begin
					run_mode_d = MODE_OFF;
					event_d    = EV_USER_STOP;
				end
			endcase
		end
		// dropping to disabled clears all counters
		if (run_mode_d == MODE_OFF) begin
			arm_rem_d  = '0;
			step_rem_d = '0;
			step_cnt_d = '0;
			pos_d      = '0;
		end
	end

	// source level numerator: (pwm_top+1) * saturated duty
	assign full      = {1'b0, pwm_top_q} + 17'd1;
	assign duty_sat  = (duty_q > DUTY_MAX) ? DUTY_MAX : duty_q;
	assign prod_full = full * duty_sat;

	// divide by 1000 and route levels by commutation position
	assign quot_full = prod_s1 * RECIP_1000;
	assign src_level = quot_full[RECIP_SHIFT +: 17];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			lvl_d[i] = '0;
		end
		if (mode_s1 == MODE_RUN) begin
			unique case (pos_s1)
				3'd0: begin lvl_d[0] = src_level; lvl_d[3] = full_s1; end
				3'd1: begin lvl_d[0] = src_level; lvl_d[5] = full_s1; end
				3'd2: begin lvl_d[2] = src_level; lvl_d[5] = full_s1; end
				3'd3: begin lvl_d[2] = src_level; lvl_d[1] = full_s1; end
				3'd4: begin lvl_d[4] = src_level; lvl_d[1] = full_s1; end
				3'd5: begin lvl_d[4] = src_level; lvl_d[3] = full_s1; end
				default: ;
			endcase
		end
	end

	// hold state and both result stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q <= MODE_OFF;
			arm_rem_q  <= '0;
			step_rem_q <= '0;
			step_cnt_q <= '0;
			pos_q      <= '0;
			valid_s1   <= 1'b0;
			mode_s1    <= MODE_OFF;
			event_s1   <= EV_NONE;
			step_s1    <= '0;
			pos_s1     <= '0;
			full_s1    <= '0;
			prod_s1    <= '0;
			valid_s2   <= 1'b0;
			mode_s2    <= '0;
			event_s2   <= EV_NONE;
			step_s2    <= '0;
			for (int i = 0; i < 6; i++) begin
				lvl_s2[i] <= '0;
			end
		end else begin
			// advance state and load stage 1 on each input transfer
			if (accept) begin
				run_mode_q <= run_mode_d;
				arm_rem_q  <= arm_rem_d;
				step_rem_q <= step_rem_d;
				step_cnt_q <= step_cnt_d;
				pos_q      <= pos_d;
				mode_s1    <= run_mode_d;
				event_s1   <= event_d;
				step_s1    <= (run_mode_d == MODE_RUN) ? step_cnt_d : 8'd0;
				pos_s1     <= pos_d;
				full_s1    <= full;
				prod_s1    <= prod_full[25:0];
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// move stage 1 into the output register
			if (advance) begin
				mode_s2  <= mode_s1;
				event_s2 <= event_s1;
				step_s2  <= step_s1;
				for (int i = 0; i < 6; i++) begin
					lvl_s2[i] <= lvl_d[i];
				end
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign driver_enable = (mode_s2 != MODE_OFF);
	assign mode          = mode_s2;
	assign event_code    = event_s2;
	assign step_number   = step_s2;
	assign u_high_level  = lvl_s2[0];
	assign u_low_level   = lvl_s2[1];
	assign v_high_level  = lvl_s2[2];
	assign v_low_level   = lvl_s2[3];
	assign w_high_level  = lvl_s2[4];
	assign w_low_level   = lvl_s2[5];

	// a running test always has a live step timer
	assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q == MODE_RUN |-> step_rem_q != 16'd0)
		else $error("step timer empty while running");

	// an armed driver always has a live timeout
	assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q == MODE_ARMED |-> arm_rem_q != 16'd0)
		else $error("arm timeout empty while armed");

	// position stays within the six steps
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("commutation position out of range");

	// a held stage 1 item is never dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stage 1 item lost");

	// no drive outside a running test
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && mode_s2 != MODE_RUN |->
		u_high_level == 17'd0 && u_low_level == 17'd0 && v_high_level == 17'd0 &&
		v_low_level == 17'd0 && w_high_level == 17'd0 && w_low_level == 17'd0)
		else $error("phase drive while not running");

endmodule

// ===== tb/tb_bldc_six_step_test_sequencer_core.sv =====
// Self-checking testbench for the six-step BLDC test sequencer core: directed
// commands, then random arm/test/stop sessions over several register settings.
// Depends on bldc6_pkg and bldc_six_step_test_sequencer_core.
`timescale 1ns / 100ps

module tb_bldc_six_step_test_sequencer_core;
	import bldc6_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int         N_PHASES   = 10;

	typedef enum logic [1:0] {SEQ_OFF = 2'd0, SEQ_ARMED = 2'd1, SEQ_RUN = 2'd2} seq_mode_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       flt;
	} cmd_item_t;

	typedef struct packed {
		logic             en;
		logic [1:0]       md;
		logic [3:0]       ev;
		logic [7:0]       step_no;
		logic [5:0][16:0] lvl;
	} drive_out_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data  = 16'd0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  op        = OP_TICK;
	logic        fault_pin = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        driver_enable;
	logic [1:0]  mode;
	logic [3:0]  event_code;
	logic [7:0]  step_number;
	logic [16:0] u_high_level, u_low_level, v_high_level;
	logic [16:0] v_low_level, w_high_level, w_low_level;

	bldc_six_step_test_sequencer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.fault_pin    (fault_pin),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.driver_enable(driver_enable),
		.mode         (mode),
		.event_code   (event_code),
		.step_number  (step_number),
		.u_high_level (u_high_level),
		.u_low_level  (u_low_level),
		.v_high_level (v_high_level),
		.v_low_level  (v_low_level),
		.w_high_level (w_high_level),
		.w_low_level  (w_low_level)
	);

	// Register copies, held at their reset values until written
	logic [15:0] set_pwm_top     = RST_PWM_TOP;
	logic [9:0]  set_duty        = RST_DUTY;
	logic [15:0] set_arm_timeout = RST_ARM_TIMEOUT;
	logic [15:0] set_step_period = RST_STEP_PERIOD;
	logic [7:0]  set_step_count  = RST_STEP_COUNT;

	// Sequencer state as the predictor tracks it
	seq_mode_t   seq_mode   = SEQ_OFF;
	logic [15:0] arm_left   = '0;
	logic [15:0] step_left  = '0;
	logic [7:0]  step_idx   = '0;
	position_t   position   = '0;

	cmd_item_t   command_backlog[$];
	drive_out_t  pending_responses[$];
	drive_out_t  want, got;
	string       lvl_name[6] = '{"u_high_level", "u_low_level", "v_high_level",
	                             "v_low_level", "w_high_level", "w_low_level"};

	int unsigned outstanding  = 0;
	int unsigned queued_total = 0;
	int unsigned results_seen = 0;
	int unsigned failures     = 0;
	logic [15:0] ev_seen      = '0;
	logic        in_xfer      = 1'b0;

	int unsigned send_gap = 0, send_run = 0;
	bit          send_quiet = 0;
	int unsigned recv_hold = 0, recv_run = 0, recv_gap = 0;
	bit          recv_quiet = 0;
	int unsigned hold_mark = 250, holds_done = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] ticks_or_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic void shut_down();
		seq_mode  = SEQ_OFF;
		arm_left  = '0;
		step_left = '0;
		step_idx  = '0;
		position  = '0;
	endfunction

	// One millisecond tick: arm countdown or step timing
	function automatic logic [3:0] tick_update(input logic flt);
		if (seq_mode == SEQ_ARMED) begin
			if (flt) begin
				shut_down();
				return EV_FAULT;
			end
			if (arm_left <= 16'd1) begin
				shut_down();
				return EV_ARM_TIMEOUT;
			end
			arm_left = arm_left - 16'd1;
		end else if (seq_mode == SEQ_RUN) begin
			if (step_left > 16'd1) begin
				step_left = step_left - 16'd1;
				return EV_NONE;
			end
			step_idx = step_idx + 8'd1;
			if (step_idx >= set_step_count) begin
				shut_down();
				return EV_COMPLETE;
			end
			position  = (position >= POS_LAST) ? position_t'(0) : position + 3'd1;
			step_left = ticks_or_one(set_step_period);
		end
		return EV_NONE;
	endfunction

	// Advance the predicted state by one command and form the drive levels
	function automatic drive_out_t sequencer_response(input logic [1:0] cmd, input logic flt);
		drive_out_t  r;
		logic [3:0]  ev;
		logic [16:0] full;
		logic [9:0]  duty;
		logic [26:0] prod;
		int          src_ph, snk_ph;
		ev = EV_NONE;
		if (seq_mode == SEQ_RUN) begin
			if (flt) begin
				shut_down();
				ev = EV_ABORT_FAULT;
			end else if (cmd == OP_STOP) begin
				shut_down();
				ev = EV_ABORT_USER;
			end else if (cmd == OP_TICK) begin
				ev = tick_update(flt);
			end
		end else if (cmd == OP_TICK) begin
			ev = tick_update(flt);
		end else if (cmd == OP_ARM) begin
			shut_down();
			if (flt) begin
				ev = EV_ARM_FAULT;
			end else begin
				seq_mode = SEQ_ARMED;
				arm_left = ticks_or_one(set_arm_timeout);
				ev       = EV_ARMED;
			end
		end else if (cmd == OP_START) begin
			if (seq_mode != SEQ_ARMED) begin
				ev = EV_REJECT_UNARMED;
			end else if (flt) begin
				shut_down();
				ev = EV_FAULT_PRETEST;
			end else if (set_step_count == 8'd0) begin
				shut_down();
				ev = EV_COMPLETE;
			end else begin
				seq_mode  = SEQ_RUN;
				arm_left  = '0;
				step_idx  = '0;
				position  = '0;
				step_left = ticks_or_one(set_step_period);
				ev        = EV_STARTED;
			end
		end else begin
			shut_down();
			ev = EV_USER_STOP;
		end

		r         = '0;
		r.en      = (seq_mode != SEQ_OFF);
		r.md      = seq_mode;
		r.ev      = ev;
		r.step_no = (seq_mode == SEQ_RUN) ? step_idx : 8'd0;
		if (seq_mode == SEQ_RUN) begin
			full = 17'(set_pwm_top) + 17'd1;
			duty = (set_duty > DUTY_MAX) ? DUTY_MAX : set_duty;
			prod = 27'(full) * 27'(duty);
			case (position)
				3'd0: begin src_ph = 0; snk_ph = 1; end
				3'd1: begin src_ph = 0; snk_ph = 2; end
				3'd2: begin src_ph = 1; snk_ph = 2; end
				3'd3: begin src_ph = 1; snk_ph = 0; end
				3'd4: begin src_ph = 2; snk_ph = 0; end
				default: begin src_ph = 2; snk_ph = 1; end
			endcase
			r.lvl[2 * src_ph]     = 17'(prod / 27'd1000);
			r.lvl[2 * snk_ph + 1] = full;
		end
		return r;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	task automatic report_field(input string name, input int unsigned exp_v,
	                            input int unsigned act_v);
		if (exp_v != act_v) begin
			failures++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			         $time, name, exp_v, act_v);
		end
	endtask

	// Predict on each input transfer; check each output transfer
	always @(posedge clk) begin
		in_xfer <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			pending_responses.push_back(sequencer_response(op, fault_pin));
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			outstanding--;
			got.en      = driver_enable;
			got.md      = mode;
			got.ev      = event_code;
			got.step_no = step_number;
			got.lvl[0]  = u_high_level;
			got.lvl[1]  = u_low_level;
			got.lvl[2]  = v_high_level;
			got.lvl[3]  = v_low_level;
			got.lvl[4]  = w_high_level;
			got.lvl[5]  = w_low_level;
			if (pending_responses.size() == 0) begin
				failures++;
				$display("%0t ns: unexpected result, expected none, actual event %0d",
				         $time, event_code);
			end else begin
				want = pending_responses.pop_front();
				ev_seen[want.ev] = 1'b1;
				report_field("driver_enable", want.en, got.en);
				report_field("mode", want.md, got.md);
				report_field("event_code", want.ev, got.ev);
				report_field("step_number", want.step_no, got.step_no);
				for (int i = 0; i < 6; i++)
					report_field(lvl_name[i], want.lvl[i], got.lvl[i]);
			end
		end
	end

	// Sender: hold the payload until transferred, then idle or offer the next item
	always @(negedge clk) begin
		cmd_item_t nxt;
		if (!in_valid || in_xfer) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (command_backlog.size() != 0) begin
				nxt = command_backlog.pop_front();
				op        <= nxt.cmd;
				fault_pin <= nxt.flt;
				in_valid  <= 1'b1;
				if (send_run == 0) begin
					send_quiet = ($urandom_range(0, 2) == 0);
					send_run   = $urandom_range(20, 120);
				end
				send_run--;
				send_gap = send_quiet ? 0 : idle_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus at most two long hold-offs on a deep backlog
	always @(negedge clk) begin
		if (recv_hold != 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else if (holds_done < 2 && results_seen >= hold_mark && outstanding > 16) begin
			out_ready <= 1'b0;
			recv_hold = 80;
			holds_done++;
			hold_mark += 600;
		end else begin
			if (recv_run == 0) begin
				recv_quiet = ($urandom_range(0, 2) == 0);
				recv_run   = $urandom_range(20, 120);
			end
			recv_run--;
			recv_gap = recv_quiet ? 0 : idle_gap();
			if (recv_gap == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				recv_hold = recv_gap - 1;
			end
		end
	end

	task automatic queue_item(input logic [1:0] cmd, input logic flt);
		command_backlog.push_back('{cmd: cmd, flt: flt});
		outstanding++;
		queued_total++;
	endtask

	task automatic wait_drained(input int unsigned settle);
		while (outstanding != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_PWM_TOP:     set_pwm_top     = val;
			REG_DUTY:        set_duty        = val[9:0];
			REG_ARM_TIMEOUT: set_arm_timeout = val;
			REG_STEP_PERIOD: set_step_period = val;
			REG_STEP_COUNT:  set_step_count  = val[7:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] pwm, input logic [9:0] duty,
	                              input logic [15:0] arm_to, input logic [15:0] period,
	                              input logic [7:0] count);
		write_reg(REG_PWM_TOP, pwm);
		write_reg(REG_DUTY, 16'(duty));
		write_reg(REG_ARM_TIMEOUT, arm_to);
		write_reg(REG_STEP_PERIOD, period);
		write_reg(REG_STEP_COUNT, 16'(count));
	endtask

	// Mostly well-formed arm/start/run sessions with random content, some noise
	task automatic fill_phase(input int unsigned budget);
		int unsigned first, k, run_len, pick;
		first = queued_total;
		while (queued_total - first < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				queue_item(OP_ARM, $urandom_range(0, 24) == 0);
				k = $urandom_range(0, 3);
				if ($urandom_range(0, 5) == 0)
					k = (ticks_or_one(set_arm_timeout) < 45) ?
					    ticks_or_one(set_arm_timeout) + 1 : 45;
				repeat (k) queue_item(OP_TICK, $urandom_range(0, 49) == 0);
				queue_item(OP_START, $urandom_range(0, 19) == 0);
				run_len = ticks_or_one(set_step_period) * set_step_count + 2;
				if (run_len > 60)
					run_len = 60;
				repeat ($urandom_range(run_len / 2, run_len)) begin
					if ($urandom_range(0, 14) == 0)
						queue_item(2'($urandom_range(1, 3)), $urandom_range(0, 3) == 0);
					else
						queue_item(OP_TICK, $urandom_range(0, 59) == 0);
				end
				if ($urandom_range(0, 2) == 0)
					queue_item(OP_STOP, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6))
					queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
			end
		end
	endtask

	initial begin
		cmd_item_t directed[25] = '{
			'{OP_TICK, 1'b0}, '{OP_TICK, 1'b1}, '{OP_STOP, 1'b0}, '{OP_START, 1'b0},
			'{OP_ARM, 1'b1}, '{OP_ARM, 1'b0}, '{OP_ARM, 1'b0}, '{OP_TICK, 1'b0},
			'{OP_TICK, 1'b1}, '{OP_ARM, 1'b0}, '{OP_START, 1'b1}, '{OP_ARM, 1'b0},
			'{OP_START, 1'b0}, '{OP_TICK, 1'b0}, '{OP_ARM, 1'b0}, '{OP_START, 1'b0},
			'{OP_STOP, 1'b0}, '{OP_ARM, 1'b0}, '{OP_START, 1'b0}, '{OP_STOP, 1'b1},
			'{OP_ARM, 1'b0}, '{OP_STOP, 1'b0}, '{OP_ARM, 1'b0}, '{OP_START, 1'b0},
			'{OP_TICK, 1'b1}
		};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Every command in every mode, on the reset settings
		foreach (directed[i])
			queue_item(directed[i].cmd, directed[i].flt);
		wait_drained(4);

		for (int ph = 1; ph <= N_PHASES; ph++) begin
			case (ph)
				1: apply_settings(16'hFFFF, 10'd1000, 16'd1, 16'd1, 8'd1);
				2: begin
					apply_settings(16'h0000, 10'd0, 16'd0, 16'd0, 8'd0);
					write_reg(REG_UNUSED, 16'hFFFF);
				end
				3: apply_settings(16'hFFFF, 10'h3FF, 16'hFFFF, 16'hFFFF, 8'hFF);
				default: apply_settings(($urandom_range(0, 3) == 0) ?
				                        16'($urandom_range(0, 15)) : 16'($urandom_range(0, 65535)),
				                        10'($urandom_range(0, 1023)),
				                        16'($urandom_range(0, 40)),
				                        16'($urandom_range(0, 6)),
				                        8'($urandom_range(0, 12)));
			endcase
			fill_phase((ph <= 3) ? 80 : 150);
			wait_drained(4);
		end

		wait_drained(8);
		if (pending_responses.size() != 0) begin
			failures++;
			$display("%0t ns: results missing, expected %0d more, actual 0",
			         $time, pending_responses.size());
		end
		$display("Summary: %0d transfers checked over %0d register settings, %0d long hold-offs",
		         results_seen, N_PHASES + 1, holds_done);
		$display("Summary: event codes reached (one bit per code) = %04h", ev_seen);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
